// ===== rtl/compressor_expander_gain_defines.svh =====
// ----------------------------------------------------------------------------
// compressor_expander_gain_defines.svh
// Assertion macros shared by the compressor/expander checker.
// ----------------------------------------------------------------------------
`ifndef COMPRESSOR_EXPANDER_GAIN_DEFINES_SVH
`define COMPRESSOR_EXPANDER_GAIN_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define CEG_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ceg: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define CEG_ASSERT_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ceg: same-cycle check failed");

// Next-cycle check that also runs during reset.
`define CEG_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ceg: reset check failed");

`endif

// ===== rtl/ceg_pkg.sv =====
// ----------------------------------------------------------------------------
// ceg_pkg
// Types, command codes and fixed-point constants of the compressor/expander.
// ----------------------------------------------------------------------------
package ceg_pkg;

    typedef struct packed {
        logic signed [23:0] left_sample;
        logic signed [23:0] right_sample;
    } ceg_in_t;

    typedef struct packed {
        logic signed [23:0] left_out;
        logic signed [23:0] right_out;
        logic signed [15:0] gain_reduction_db;
    } ceg_out_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_RATIO     = 3'd1,
        CFG_ATTACK    = 3'd2,
        CFG_RELEASE   = 3'd3,
        CFG_MAKEUP    = 3'd4,
        CFG_EXPANDER  = 3'd5,
        CFG_BYPASS    = 3'd6
    } ceg_cfg_idx_t;

    localparam logic signed [14:0] THRESHOLD_RST = -15'sd5120;
    localparam logic [14:0]        RATIO_RST     = 15'd1024;
    localparam logic [15:0]        ATTACK_RST    = 16'd65000;
    localparam logic [15:0]        RELEASE_RST   = 16'd65500;
    localparam logic [13:0]        MAKEUP_RST    = 14'd0;

    localparam logic [31:0]        LEVEL_FLOOR   = 32'd2147;
    localparam logic signed [15:0] DB_FLOOR      = -16'sd15360;
    localparam logic signed [11:0] AVG_NEW       = 12'sd1678;
    localparam logic signed [18:0] DB_PER_LOG2   = 19'sd197283;
    localparam logic signed [23:0] LOG2_PER_DB   = 24'sd2786635;
    localparam logic signed [21:0] LOG_OFFSET    = 22'sd2031616;
    localparam logic signed [25:0] EXP_CAP       = 26'sd1966079;
    localparam logic [14:0]        RATIO_MIN     = 15'd256;

    localparam int LOG_STEPS  = 16;
    localparam int DIV_STEPS  = 24;
    localparam int SQRT_ITERS = 32;
    localparam int SQRT_ROUNDS = 16;

    typedef enum logic [4:0] {
        OP_NONE     = 5'd0,
        OP_CAPTURE  = 5'd1,
        OP_SQUARE   = 5'd2,
        OP_LEVEL    = 5'd3,
        OP_NORM     = 5'd4,
        OP_LOG      = 5'd5,
        OP_DB       = 5'd6,
        OP_DIFF     = 5'd7,
        OP_DIV      = 5'd8,
        OP_XL       = 5'd9,
        OP_SMOOTH1  = 5'd10,
        OP_SMOOTH2  = 5'd11,
        OP_GAIN     = 5'd12,
        OP_SQ_PREP  = 5'd13,
        OP_SQ_ITER  = 5'd14,
        OP_MUL      = 5'd15,
        OP_SCALE    = 5'd16,
        OP_RESULT   = 5'd17
    } ceg_op_t;

    typedef struct packed {
        ceg_op_t    op;
        logic [4:0] cnt;
        logic [3:0] k;
        logic       lane;
    } ceg_cmd_t;

    typedef struct packed {
        logic lev_floor;
        logic x_msb;
        logic expander;
        logic bypass;
    } ceg_status_t;

endpackage

// ===== rtl/compressor_expander_gain.sv =====
// ----------------------------------------------------------------------------
// compressor_expander_gain
// Feedforward log-domain compressor/expander gain stage for stereo frames.
// Each transaction on the s_ channel carries one stereo frame; the result on
// the m_ channel carries both scaled samples and the smoothed gain reduction.
// One frame is processed at a time. A normal frame passes through level
// normalization, 16 squaring steps for log2 (skipped at the level floor), 24
// steps of the ratio divider in compressor mode, and 16 square roots (setup
// plus 32 iterations each) for the fractional power of two, which dominate.
// The block returns to idle in the same cycle that the result is registered.
// In bypass the sequencer goes from acceptance straight to the finish state,
// where the result is registered once the output register is free.
// A new frame is accepted while the previous result still waits on m_ready.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_wdata;
// the user must write them only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module compressor_expander_gain (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ceg_pkg::ceg_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ceg_pkg::ceg_out_t              m_data,
    input  logic                           cfg_wr_en,
    input  logic [ceg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ceg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // Command and status between sequencer and datapath.
    ceg_pkg::ceg_cmd_t    cmd;
    ceg_pkg::ceg_status_t status;

    // Sequencer: accepts a transaction, walks the datapath, and parks the
    // result in the output register once the previous one has been taken.
    ceg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath: holds configuration, the level estimate and the smoothed
    // reduction, and drives the result register straight onto m_data.
    ceg_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_data)
    );

endmodule

// ===== rtl/ceg_ctrl.sv =====
// ----------------------------------------------------------------------------
// ceg_ctrl
// Sequencer: steps the datapath through one frame and owns the handshakes.
// ----------------------------------------------------------------------------
module ceg_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  ceg_pkg::ceg_status_t status,
    output ceg_pkg::ceg_cmd_t    cmd
);

    typedef enum logic [17:0] {
        ST_IDLE    = 18'd1 << 0,
        ST_SQUARE  = 18'd1 << 1,
        ST_LEVEL   = 18'd1 << 2,
        ST_NORM    = 18'd1 << 3,
        ST_LOG     = 18'd1 << 4,
        ST_DB      = 18'd1 << 5,
        ST_DIFF    = 18'd1 << 6,
        ST_DIV     = 18'd1 << 7,
        ST_XL      = 18'd1 << 8,
        ST_SMOOTH1 = 18'd1 << 9,
        ST_SMOOTH2 = 18'd1 << 10,
        ST_GAIN    = 18'd1 << 11,
        ST_SQ_PREP = 18'd1 << 12,
        ST_SQ_ITER = 18'd1 << 13,
        ST_MUL     = 18'd1 << 14,
        ST_SCALE   = 18'd1 << 15,
        ST_FINISH  = 18'd1 << 16,
        ST_SPARE   = 18'd1 << 17
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [3:0] k_reg, k_next;
    logic       lane_reg, lane_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        lane_next    = lane_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.op       = ceg_pkg::OP_NONE;
        cmd.cnt      = cnt_reg;
        cmd.k        = k_reg;
        cmd.lane     = lane_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = ceg_pkg::OP_CAPTURE;
                    state_next = status.bypass ? ST_FINISH : ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.op     = ceg_pkg::OP_SQUARE;
                state_next = ST_LEVEL;
            end
            ST_LEVEL: begin
                cmd.op     = ceg_pkg::OP_LEVEL;
                state_next = ST_NORM;
            end
            ST_NORM: begin
                if (status.lev_floor) begin
                    state_next = ST_DB;
                end else if (status.x_msb) begin
                    cnt_next   = '0;
                    state_next = ST_LOG;
                end else begin
                    cmd.op = ceg_pkg::OP_NORM;
                end
            end
            ST_LOG: begin
                cmd.op   = ceg_pkg::OP_LOG;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(ceg_pkg::LOG_STEPS - 1)) begin
                    state_next = ST_DB;
                end
            end
            ST_DB: begin
                cmd.op     = ceg_pkg::OP_DB;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.op     = ceg_pkg::OP_DIFF;
                cnt_next   = '0;
                state_next = status.expander ? ST_XL : ST_DIV;
            end
            ST_DIV: begin
                cmd.op   = ceg_pkg::OP_DIV;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(ceg_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_XL;
                end
            end
            ST_XL: begin
                cmd.op     = ceg_pkg::OP_XL;
                state_next = ST_SMOOTH1;
            end
            ST_SMOOTH1: begin
                cmd.op     = ceg_pkg::OP_SMOOTH1;
                state_next = ST_SMOOTH2;
            end
            ST_SMOOTH2: begin
                cmd.op     = ceg_pkg::OP_SMOOTH2;
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                cmd.op     = ceg_pkg::OP_GAIN;
                k_next     = '0;
                state_next = ST_SQ_PREP;
            end
            ST_SQ_PREP: begin
                cmd.op     = ceg_pkg::OP_SQ_PREP;
                cnt_next   = '0;
                state_next = ST_SQ_ITER;
            end
            ST_SQ_ITER: begin
                cmd.op   = ceg_pkg::OP_SQ_ITER;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(ceg_pkg::SQRT_ITERS - 1)) begin
                    if (k_reg == 4'(ceg_pkg::SQRT_ROUNDS - 1)) begin
                        lane_next  = 1'b0;
                        state_next = ST_MUL;
                    end else begin
                        k_next     = k_reg + 4'd1;
                        state_next = ST_SQ_PREP;
                    end
                end
            end
            ST_MUL: begin
                cmd.op     = ceg_pkg::OP_MUL;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.op = ceg_pkg::OP_SCALE;
                if (!lane_reg) begin
                    lane_next  = 1'b1;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.op       = ceg_pkg::OP_RESULT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            k_reg       <= '0;
            lane_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            k_reg       <= k_next;
            lane_reg    <= lane_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/ceg_datapath.sv =====
// ----------------------------------------------------------------------------
// ceg_datapath
// Configuration registers, level detector, log, curve, smoother, exp, scaler.
// ----------------------------------------------------------------------------
module ceg_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ceg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ceg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  ceg_pkg::ceg_in_t                 in_data,
    input  ceg_pkg::ceg_cmd_t                cmd,
    output ceg_pkg::ceg_status_t             status,
    output ceg_pkg::ceg_out_t                out_data
);

    // configuration
    logic signed [14:0] threshold_reg;
    logic [14:0]        ratio_reg;
    logic [15:0]        attack_reg;
    logic [15:0]        release_reg;
    logic [13:0]        makeup_reg;
    logic               expander_reg;
    logic               bypass_reg;

    // frame state kept across items
    logic [31:0]        lev_reg;
    logic signed [15:0] y_reg;

    // working registers
    logic signed [23:0] l_in_reg, r_in_reg, mono_reg;
    logic [31:0]        sq_reg, x_reg;
    logic [4:0]         n_reg;
    logic [15:0]        frac_reg;
    logic signed [15:0] xg_reg, xl_reg;
    logic signed [16:0] diff_reg;
    logic [14:0]        rem_reg;
    logic [23:0]        quo_reg;
    logic signed [32:0] p1_reg;
    logic [16:0]        am_reg;
    logic signed [21:0] e16_reg;
    logic [63:0]        sqv_reg, sqr_reg, sqb_reg;
    logic signed [56:0] prod_reg;
    logic signed [23:0] outl_reg, outr_reg;
    ceg_pkg::ceg_out_t  result_reg;

    // combinational terms
    logic signed [24:0] sum_lr, sum_adj;
    logic signed [47:0] sq_full;
    logic signed [33:0] avg_dlt, lev_avg;
    logic signed [45:0] avg_prod;
    logic [31:0]        lev_new;
    logic [63:0]        xx;
    logic [32:0]        xt;
    logic signed [21:0] logval;
    logic signed [40:0] dbp, dbs;
    logic [14:0]        r_eff;
    logic [15:0]        div_sh;
    logic               div_ge;
    logic signed [32:0] ep, eps;
    logic signed [24:0] ers;
    logic signed [25:0] xt_exp, xt_cmp, xl_raw;
    logic signed [15:0] xl_sat;
    logic               use_attack;
    logic [15:0]        alpha;
    logic signed [33:0] am_prod;
    logic signed [34:0] s2;
    logic signed [17:0] g;
    logic signed [41:0] gp, gsum;
    logic signed [25:0] e_full;
    logic signed [5:0]  ip;
    logic [15:0]        f;
    logic [32:0]        mant_src;
    logic [63:0]        sq_t;
    logic signed [23:0] smp;
    logic [6:0]         sh;
    logic signed [63:0] sc_ext, sc_sum, sc_shift;
    logic signed [23:0] sc_sat;

    assign status.lev_floor = (lev_reg <= ceg_pkg::LEVEL_FLOOR);
    assign status.x_msb     = x_reg[31];
    assign status.expander  = expander_reg;
    assign status.bypass    = bypass_reg;
    assign out_data         = result_reg;

    always_comb begin
        // mono mix, truncated toward zero
        sum_lr  = 25'(in_data.left_sample) + 25'(in_data.right_sample);
        sum_adj = sum_lr + $signed({24'd0, sum_lr[24]});
        sq_full = mono_reg * mono_reg;

        // level = lev + floor((sq - lev) * 1678 / 2^24) in expander mode
        avg_dlt  = $signed({2'b00, sq_reg}) - $signed({2'b00, lev_reg});
        avg_prod = avg_dlt * ceg_pkg::AVG_NEW;
        lev_avg  = $signed({2'b00, lev_reg}) + 34'($signed(avg_prod[45:24]));
        lev_new  = expander_reg ? lev_avg[31:0] : sq_reg;

        xx = 64'(x_reg) * 64'(x_reg);
        xt = xx[63:31];

        logval = $signed({1'b0, n_reg, frac_reg}) - ceg_pkg::LOG_OFFSET;
        dbp    = logval * ceg_pkg::DB_PER_LOG2;
        dbs    = dbp + 41'sd8388608;

        r_eff  = (ratio_reg < ceg_pkg::RATIO_MIN) ? ceg_pkg::RATIO_MIN : ratio_reg;
        div_sh = {rem_reg, quo_reg[23]};
        div_ge = (div_sh >= {1'b0, r_eff});

        ep     = diff_reg * $signed({1'b0, r_eff});
        eps    = ep + 33'sd128;
        ers    = eps[32:8];
        xt_exp = 26'(diff_reg) - 26'(ers);
        xt_cmp = 26'(diff_reg) - 26'($signed({1'b0, quo_reg}));
        if (expander_reg) begin
            xl_raw = (diff_reg > 17'sd0) ? 26'sd0 : xt_exp;
        end else begin
            xl_raw = (diff_reg < 17'sd0) ? 26'sd0 : xt_cmp;
        end
        if (xl_raw > 26'sd32767) begin
            xl_sat = 16'sh7FFF;
        end else if (xl_raw < -26'sd32768) begin
            xl_sat = 16'sh8000;
        end else begin
            xl_sat = xl_raw[15:0];
        end

        use_attack = expander_reg ? (xl_reg < y_reg) : (xl_reg > y_reg);
        alpha      = use_attack ? attack_reg : release_reg;
        am_prod    = $signed({1'b0, am_reg}) * xl_reg;
        s2         = 35'(p1_reg) + 35'(am_prod) + 35'sd32768;

        g      = $signed({4'b0000, makeup_reg}) - 18'(y_reg);
        gp     = g * ceg_pkg::LOG2_PER_DB;
        gsum   = gp + 42'sd32768;
        e_full = gsum[41:16];

        ip       = e16_reg[21:16];
        f        = e16_reg[15:0];
        mant_src = f[cmd.k] ? {sqr_reg[31:0], 1'b0} : {1'b0, sqr_reg[31:0]};
        sq_t     = sqr_reg + sqb_reg;

        smp      = cmd.lane ? r_in_reg : l_in_reg;
        sh       = 7'd30 - 7'(ip);
        sc_ext   = 64'(prod_reg);
        sc_sum   = sc_ext + (64'sd1 <<< (sh - 7'd1));
        sc_shift = sc_sum >>> sh;
        if (sc_shift > 64'sd8388607) begin
            sc_sat = 24'sh7FFFFF;
        end else if (sc_shift < -64'sd8388608) begin
            sc_sat = 24'sh800000;
        end else begin
            sc_sat = sc_shift[23:0];
        end
    end

    // configuration and persistent state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= ceg_pkg::THRESHOLD_RST;
            ratio_reg     <= ceg_pkg::RATIO_RST;
            attack_reg    <= ceg_pkg::ATTACK_RST;
            release_reg   <= ceg_pkg::RELEASE_RST;
            makeup_reg    <= ceg_pkg::MAKEUP_RST;
            expander_reg  <= 1'b0;
            bypass_reg    <= 1'b0;
            lev_reg       <= '0;
            y_reg         <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (ceg_pkg::ceg_cfg_idx_t'(cfg_index))
                    ceg_pkg::CFG_THRESHOLD: threshold_reg <= $signed(cfg_wdata[14:0]);
                    ceg_pkg::CFG_RATIO:     ratio_reg     <= cfg_wdata[14:0];
                    ceg_pkg::CFG_ATTACK:    attack_reg    <= cfg_wdata;
                    ceg_pkg::CFG_RELEASE:   release_reg   <= cfg_wdata;
                    ceg_pkg::CFG_MAKEUP:    makeup_reg    <= cfg_wdata[13:0];
                    ceg_pkg::CFG_EXPANDER:  expander_reg  <= cfg_wdata[0];
                    ceg_pkg::CFG_BYPASS:    bypass_reg    <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.op == ceg_pkg::OP_LEVEL) begin
                lev_reg <= lev_new;
            end
            if (cmd.op == ceg_pkg::OP_SMOOTH2) begin
                y_reg <= s2[31:16];
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            ceg_pkg::OP_CAPTURE: begin
                l_in_reg <= in_data.left_sample;
                r_in_reg <= in_data.right_sample;
                mono_reg <= sum_adj[24:1];
            end
            ceg_pkg::OP_SQUARE: begin
                sq_reg <= sq_full[46:15];
            end
            ceg_pkg::OP_LEVEL: begin
                x_reg    <= lev_new;
                n_reg    <= 5'd31;
                frac_reg <= '0;
            end
            ceg_pkg::OP_NORM: begin
                x_reg <= {x_reg[30:0], 1'b0};
                n_reg <= n_reg - 5'd1;
            end
            ceg_pkg::OP_LOG: begin
                if (xt[32]) begin
                    x_reg <= xt[32:1];
                    frac_reg[4'd15 - cmd.cnt[3:0]] <= 1'b1;
                end else begin
                    x_reg <= xt[31:0];
                end
            end
            ceg_pkg::OP_DB: begin
                xg_reg <= status.lev_floor ? ceg_pkg::DB_FLOOR : dbs[39:24];
            end
            ceg_pkg::OP_DIFF: begin
                diff_reg <= 17'(xg_reg) - 17'(threshold_reg);
                rem_reg  <= '0;
                quo_reg  <= {xg_reg - 16'(threshold_reg), 8'd0};
            end
            ceg_pkg::OP_DIV: begin
                rem_reg <= div_ge ? 15'(div_sh - {1'b0, r_eff}) : div_sh[14:0];
                quo_reg <= {quo_reg[22:0], div_ge};
            end
            ceg_pkg::OP_XL: begin
                xl_reg <= xl_sat;
            end
            ceg_pkg::OP_SMOOTH1: begin
                p1_reg <= $signed({1'b0, alpha}) * y_reg;
                am_reg <= 17'h10000 - {1'b0, alpha};
            end
            ceg_pkg::OP_GAIN: begin
                e16_reg <= (e_full > ceg_pkg::EXP_CAP) ? 22'(ceg_pkg::EXP_CAP) : e_full[21:0];
                sqr_reg <= 64'd1 << 30;
            end
            ceg_pkg::OP_SQ_PREP: begin
                sqv_reg <= 64'({mant_src, 30'd0});
                sqr_reg <= '0;
                sqb_reg <= 64'd1 << 62;
            end
            ceg_pkg::OP_SQ_ITER: begin
                if (sqv_reg >= sq_t) begin
                    sqv_reg <= sqv_reg - sq_t;
                    sqr_reg <= (sqr_reg >> 1) + sqb_reg;
                end else begin
                    sqr_reg <= sqr_reg >> 1;
                end
                sqb_reg <= sqb_reg >> 2;
            end
            ceg_pkg::OP_MUL: begin
                prod_reg <= smp * $signed({1'b0, sqr_reg[31:0]});
            end
            ceg_pkg::OP_SCALE: begin
                if (cmd.lane) begin
                    outr_reg <= sc_sat;
                end else begin
                    outl_reg <= sc_sat;
                end
            end
            ceg_pkg::OP_RESULT: begin
                result_reg.left_out          <= bypass_reg ? l_in_reg : outl_reg;
                result_reg.right_out         <= bypass_reg ? r_in_reg : outr_reg;
                result_reg.gain_reduction_db <= y_reg;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/ceg_checker.sv =====
// ----------------------------------------------------------------------------
// ceg_checker
// Port-level checks of the compressor/expander, bound to the top level.
// ----------------------------------------------------------------------------
`include "compressor_expander_gain_defines.svh"

module ceg_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input ceg_pkg::ceg_out_t m_data
);

    // Hold a stalled result.
    `CEG_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // One frame in flight: drop ready after each accepted transaction.
    `CEG_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)

    // A new result appears only as the block returns to idle.
    `CEG_ASSERT_SAME(a_result_at_idle, aclk, aresetn, $rose(m_valid), s_ready)

    // Leave reset idle and empty.
    `CEG_ASSERT_NEXT_ALWAYS(a_reset_state, aclk, !aresetn, s_ready && !m_valid)

endmodule

bind compressor_expander_gain ceg_checker u_ceg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
